// ===== sv/lvs_pkg.sv =====
// Shared types and constants for the LRU victim selector with protect bits.
`default_nettype none
package lvs_pkg;

	localparam int STAMP_W  = 64;
	localparam int SETS_DEF = 64;
	localparam int WAYS_DEF = 16;

	localparam int MODE_W   = 2;
	localparam int SET_W    = 6;
	localparam int WAY_W    = 4;
	localparam int VWAY_W   = 4;

	localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FILL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SET_W-1:0]  set_index;
		logic [WAY_W-1:0]  way;
		logic              hit;
		logic              is_write;
	} req_t;

	typedef struct packed {
		logic [VWAY_W-1:0] victim_way;
		logic              victim_valid;
		logic              all_protected;
	} rsp_t;

endpackage
`default_nettype wire

// ===== sv/lvs_req_if.sv =====
// Request channel: valid/ready handshake carrying one replacement request.
`default_nettype none
interface lvs_req_if;
	logic          valid;
	logic          ready;
	lvs_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/lvs_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one replacement result.
`default_nettype none
interface lvs_rsp_if;
	logic          valid;
	logic          ready;
	lvs_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/lru_victim_select_with_protect_top.sv =====
// LRU victim selection with per-line protect bits: set-row memories and min-reduction tree.
// Victim request: one memory read, then one tree level per cycle; the result is registered
//   once the response register is free, and only then is the next request taken.
// Fill or access update: row read, then read-modify-write of the set row; the next request
//   is taken only after its result is registered.
// Reset: clears the use counter, then a clearing pass writes zero to one set row per cycle
//   through all SETS rows, during which no request is taken.
`default_nettype none
module lru_victim_select_with_protect_top #(
	parameter int SETS = lvs_pkg::SETS_DEF,
	parameter int WAYS = lvs_pkg::WAYS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	lvs_req_if.sink    req,
	lvs_rsp_if.source  rsp
);

	localparam int AW = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WW = $clog2(WAYS);
	localparam int P  = 1 << WW;
	localparam int SW = lvs_pkg::STAMP_W;
	localparam int KW = SW + 1;
	localparam int CW = (WW > 1) ? $clog2(WW) : 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_RED  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       red_q;
	logic [SW-1:0]       ctr_q;
	lvs_pkg::req_t       item_q;
	lvs_pkg::rsp_t       res_q;
	logic                rsp_valid_q;
	lvs_pkg::rsp_t       rsp_data_q;
	logic [KW-1:0]       key_q [P];
	logic [WW-1:0]       idx_q [P];

	logic [WAYS-1:0][SW-1:0] st_row;
	logic [WAYS-1:0][SW-1:0] st_wdata;
	logic [WAYS-1:0]         pr_row;
	logic [WAYS-1:0]         pr_wdata;
	logic                    st_we;
	logic                    pr_we;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;

	logic          accept;
	logic          set_ok;
	logic          way_ok;
	logic          is_victim;
	logic          touch;
	logic          restamp;
	logic          prot_new;
	logic [WW-1:0] way_idx;
	logic [AW-1:0] set_addr;
	logic          rsp_free;

	logic [KW-1:0] leaf_key [P];
	logic [WW-1:0] leaf_idx [P];
	logic [KW-1:0] nkey [P];
	logic [WW-1:0] nidx [P];

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign set_ok    = int'(item_q.set_index) < SETS;
	assign way_ok    = int'(item_q.way) < WAYS;
	assign way_idx   = WW'(item_q.way);
	assign set_addr  = AW'(item_q.set_index);
	assign is_victim = (item_q.mode == lvs_pkg::MODE_VICTIM);
	assign touch     = ((item_q.mode == lvs_pkg::MODE_FILL) ||
	                    (item_q.mode == lvs_pkg::MODE_UPDATE)) && set_ok && way_ok;
	assign prot_new  = (item_q.mode == lvs_pkg::MODE_UPDATE) && item_q.hit && !item_q.is_write;
	assign restamp   = touch && ((item_q.mode == lvs_pkg::MODE_FILL) || prot_new);
	assign raddr     = AW'(req.data.set_index);

	// write port: clearing pass after reset, else write back the modified set row
	always_comb begin
		st_wdata = st_row;
		pr_wdata = pr_row;
		st_wdata[way_idx] = ctr_q;
		pr_wdata[way_idx] = prot_new;
		st_we = 1'b0;
		pr_we = 1'b0;
		waddr = set_addr;
		case (state_q)
			ST_CLR: begin
				st_wdata = '0;
				pr_wdata = '0;
				st_we    = 1'b1;
				pr_we    = 1'b1;
				waddr    = clr_q;
			end
			ST_RD: begin
				st_we = restamp;
				pr_we = touch;
			end
			default: begin
				st_we = 1'b0;
				pr_we = 1'b0;
			end
		endcase
	end

	lvs_ram #(.WIDTH(WAYS * SW), .DEPTH(SETS)) u_stamp_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (waddr),
		.wdata (st_wdata),
		.raddr (raddr),
		.rdata (st_row)
	);

	lvs_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_prot_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (waddr),
		.wdata (pr_wdata),
		.raddr (raddr),
		.rdata (pr_row)
	);

	// key = {protect, stamp}: unprotected ways win, then oldest; padding never wins a tie
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < WAYS) begin : g_way
			assign leaf_key[i] = {pr_row[i], st_row[i]};
		end else begin : g_pad
			assign leaf_key[i] = {KW{1'b1}};
		end
		assign leaf_idx[i] = WW'(i);
	end

	// one tree level: the left entry keeps ties so the lowest way wins
	always_comb begin
		for (int i = 0; i < P; i++) begin
			nkey[i] = key_q[i];
			nidx[i] = idx_q[i];
		end
		for (int i = 0; i < P / 2; i++) begin
			if (key_q[2*i+1] < key_q[2*i]) begin
				nkey[i] = key_q[2*i+1];
				nidx[i] = idx_q[2*i+1];
			end else begin
				nkey[i] = key_q[2*i];
				nidx[i] = idx_q[2*i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req.data;
		end
		if (state_q == ST_RD) begin
			for (int i = 0; i < P; i++) begin
				key_q[i] <= leaf_key[i];
				idx_q[i] <= leaf_idx[i];
			end
		end else if (state_q == ST_RED) begin
			for (int i = 0; i < P; i++) begin
				key_q[i] <= nkey[i];
				idx_q[i] <= nidx[i];
			end
		end
		if (state_q == ST_RD) begin
			res_q.victim_way    <= '0;
			res_q.victim_valid  <= is_victim;
			res_q.all_protected <= 1'b0;
		end else if (state_q == ST_RED && red_q == CW'(WW - 1)) begin
			res_q.victim_way    <= lvs_pkg::VWAY_W'(nidx[0]);
			res_q.victim_valid  <= 1'b1;
			res_q.all_protected <= nkey[0][KW-1];
		end
		if (state_q == ST_FIN && rsp_free) begin
			rsp_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			red_q       <= '0;
			ctr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (clr_q == AW'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_q <= clr_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					red_q <= '0;
					if (restamp) begin
						ctr_q <= ctr_q + SW'(1);
					end
					state_q <= (is_victim && set_ok) ? ST_RED : ST_FIN;
				end
				ST_RED: begin
					if (red_q == CW'(WW - 1)) begin
						state_q <= ST_FIN;
					end
					red_q <= red_q + CW'(1);
				end
				ST_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// hold the result until its transfer; a finished item reloads it
			if (state_q == ST_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RD))
		else $error("request transfer not followed by row read");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctr_q != $past(ctr_q)) |-> (($past(state_q) == ST_RD) && (ctr_q == $past(ctr_q) + SW'(1))))
		else $error("use counter moved outside a restamp");

	a_restamp_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we && (state_q == ST_RD)) |=> (ctr_q == $past(ctr_q) + SW'(1)))
		else $error("restamp without counter advance");

	a_fallback_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.all_protected) |-> rsp.data.victim_valid)
		else $error("fallback flag on a non-victim result");
`endif

endmodule
`default_nettype wire

// ===== sv/lvs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
